// ----- sv/double_ended_queue_core_macros.svh -----
// Assertion macros used by the deque datapath.
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DEQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/deq_pkg.sv -----
// Types and constants shared by the deque modules.
package deq_pkg;

   localparam int OP_W     = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_REAR   = 3'd3,
      OP_LIST       = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_BUSY
   } ctrl_state_type;

   typedef struct packed {
      logic ready;
      logic start;
      logic issue;
      logic consume;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic needs_read;
      logic pend_valid;
      logic out_free;
      logic rem_zero;
   } dp_status_type;

endpackage

// ----- sv/deq_if.sv -----
// Request and response channel interfaces of the deque.
interface deq_req_if;
   import deq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [DATA_W-1:0] value;
   modport source (output valid, output op, output value, input ready);
   modport sink (input valid, input op, input value, output ready);
endinterface

interface deq_rsp_if;
   import deq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [DATA_W-1:0] item;
   logic                     last;
   modport source (output valid, output status, output item, output last, input ready);
   modport sink (input valid, input status, input item, input last, output ready);
endinterface

// ----- sv/deq_ctrl.sv -----
// Controller state machine of the deque: request intake and read sequencing.
module deq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  deq_pkg::dp_status_type sts,
   output deq_pkg::ctrl_cmd_type  cmd
);
   import deq_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (sts.req_valid && sts.out_free && sts.needs_read) begin
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            // Leave once the final read result moves into the output register.
            if (sts.pend_valid && sts.out_free && sts.rem_zero) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.ready = sts.out_free;
            cmd.start = sts.req_valid && sts.out_free;
         end
         S_BUSY: begin
            cmd.consume = sts.pend_valid && sts.out_free;
            cmd.issue   = !sts.rem_zero && (!sts.pend_valid || cmd.consume);
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- sv/deq_dp.sv -----
// Datapath of the deque: ring buffer storage, pointers and output register.
`include "double_ended_queue_core_macros.svh"
module deq_dp #(
   parameter int DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  deq_pkg::ctrl_cmd_type  cmd,
   output deq_pkg::dp_status_type sts,
   deq_req_if.sink                req,
   deq_rsp_if.source              rsp
);
   import deq_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
   localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

   function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                              input logic [IW-1:0] offs);
      logic [IW:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= (IW + 1)'(DEPTH)) begin
         sum = sum - (IW + 1)'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   logic [DATA_W-1:0]   slots_ff [DEPTH];
   logic [DATA_W-1:0]   rdata_ff;
   logic [IW-1:0]       front_ff, front_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       rem_ff, rem_in;
   logic [IW-1:0]       offs_ff, offs_in;
   logic                pend_ff, pend_in;
   logic                pend_last_ff, pend_last_in;
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff;
   logic [DATA_W-1:0]   out_item_ff;
   logic                out_last_ff;

   op_type              req_op;
   logic                empty, full;
   logic [CW-1:0]       cnt_m1;
   logic                wr_en, rd_en;
   logic [IW-1:0]       wr_addr, rd_addr;
   logic                load;
   status_type          ld_status;
   logic [DATA_W-1:0]   ld_item;
   logic                ld_last;

   assign req_op = op_type'(req.op);
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == DEPTH_C);
   assign cnt_m1 = count_ff - CW'(1);

   assign req.ready = cmd.ready;

   always_comb begin
      sts.req_valid  = req.valid;
      sts.needs_read = (req_op inside {OP_POP_FRONT, OP_POP_REAR, OP_LIST}) && !empty;
      sts.pend_valid = pend_ff;
      sts.out_free   = !out_valid_ff || rsp.ready;
      sts.rem_zero   = (rem_ff == '0);
   end

   always_comb begin
      front_in     = front_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      offs_in      = offs_ff;
      pend_last_in = pend_last_ff;
      wr_en        = 1'b0;
      wr_addr      = front_ff;
      rd_en        = 1'b0;
      rd_addr      = front_ff;
      load         = 1'b0;
      ld_status    = ST_OK;
      ld_item      = '0;
      ld_last      = 1'b1;
      if (cmd.start) begin
         case (req_op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
               load = 1'b1;
               if (full) begin
                  ld_status = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  if (req_op == OP_PUSH_FRONT) begin
                     front_in = (front_ff == '0) ? LAST_IDX : front_ff - IW'(1);
                     wr_addr  = front_in;
                  end else begin
                     wr_addr = wrap_add(front_ff, count_ff[IW-1:0]);
                  end
               end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
               if (empty) begin
                  load      = 1'b1;
                  ld_status = ST_EMPTY;
               end else begin
                  rd_en        = 1'b1;
                  count_in     = cnt_m1;
                  rem_in       = '0;
                  pend_last_in = 1'b1;
                  if (req_op == OP_POP_FRONT) begin
                     rd_addr  = front_ff;
                     front_in = (front_ff == LAST_IDX) ? '0 : front_ff + IW'(1);
                  end else begin
                     rd_addr = wrap_add(front_ff, cnt_m1[IW-1:0]);
                  end
               end
            end
            OP_LIST: begin
               if (empty) begin
                  load      = 1'b1;
                  ld_status = ST_EMPTY;
               end else begin
                  rd_en        = 1'b1;
                  rd_addr      = front_ff;
                  rem_in       = cnt_m1;
                  offs_in      = IW'(1);
                  pend_last_in = (cnt_m1 == '0);
               end
            end
            default: begin
               // Undefined operations are consumed without any result.
            end
         endcase
      end else begin
         if (cmd.consume) begin
            load    = 1'b1;
            ld_item = rdata_ff;
            ld_last = pend_last_ff;
         end
         if (cmd.issue) begin
            rd_en        = 1'b1;
            rd_addr      = wrap_add(front_ff, offs_ff);
            offs_in      = offs_ff + IW'(1);
            rem_in       = rem_ff - CW'(1);
            pend_last_in = (rem_ff == CW'(1));
         end
      end
   end

   // A read result stays pending until the output register takes it.
   assign pend_in      = rd_en || (pend_ff && !cmd.consume);
   assign out_valid_in = load || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      offs_ff      <= offs_in;
      pend_last_ff <= pend_last_in;
      if (load) begin
         out_status_ff <= ld_status;
         out_item_ff   <= ld_item;
         out_last_ff   <= ld_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= req.value;
      end
      if (rd_en) begin
         rdata_ff <= slots_ff[rd_addr];
      end
   end

   assign rsp.valid  = out_valid_ff;
   assign rsp.status = out_status_ff;
   assign rsp.item   = out_item_ff;
   assign rsp.last   = out_last_ff;

   `DEQ_ASSERT(a_count_bound, count_ff <= DEPTH_C, "stored count exceeds depth")
   `DEQ_ASSERT(a_load_free, load |-> (!out_valid_ff || rsp.ready), "output register overwritten")
   `DEQ_ASSERT(a_pend_no_intake, pend_ff |-> !cmd.ready, "intake open while a read is pending")
   `DEQ_ASSERT_NEXT(a_pop_count, cmd.start && !empty && (req_op == OP_POP_FRONT || req_op == OP_POP_REAR), count_ff == $past(count_ff) - CW'(1), "pop did not shrink the count")

endmodule

// ----- sv/double_ended_queue_core.sv -----
// Push results and empty pop or list results reach the output register in the next cycle.
// A pop result passes the read data register, then the output register once it is free;
// intake reopens when the result is registered. A list of N entries gives N results, the
// first by the same path, then one per cycle while the response side takes them; intake
// stays closed until the last is loaded. Pushes go one per cycle while the output is free.
// Synchronous reset empties the queue and the controller; slot contents are not cleared.
module double_ended_queue_core #(
   parameter int DEPTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_bus,
   deq_rsp_if.source rsp_bus
);
   import deq_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   deq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   deq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

endmodule

// ----- tb/double_ended_queue_core_tb.sv -----
// Self-checking testbench for the double-ended queue core: table-driven and random checks.
`timescale 1ns / 100ps

module double_ended_queue_core_tb;
   import deq_pkg::*;

   localparam int STORE_DEPTH = 32;
   localparam int RANDOM_ITEMS = 50;
   localparam int CALM_TAIL_START = 40;
   localparam int NUM_DIRECTED = 24;

   // Op codes the block does not define; it must drop them without a response.
   localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
   localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] item;
      logic                     last;
   } rsp_fields_type;

   typedef struct {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
      int                       reps;
      bit                       typed;
      status_type               exp_status;
      logic signed [DATA_W-1:0] exp_item;
      logic                     exp_last;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   deq_req_if req_bus ();
   deq_rsp_if rsp_bus ();

   double_ended_queue_core #(
      .DEPTH(STORE_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   logic signed [DATA_W-1:0] stored_values [$];
   rsp_fields_type           pending_rsp_q [$];
   stim_row_type             directed_rows [NUM_DIRECTED];
   int                       fail_count = 0;
   bit                       calm_tail = 1'b0;

   always #5 clock = ~clock;

   // Applies one accepted transaction to the queue image and records the responses it owes.
   function automatic void apply_deque_op(input logic [OP_W-1:0] op,
                                          input logic signed [DATA_W-1:0] value,
                                          input bit typed, input rsp_fields_type typed_rsp);
      rsp_fields_type r;
      int             n;
      r.status = ST_OK;
      r.item   = '0;
      r.last   = 1'b1;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (stored_values.size() >= STORE_DEPTH) begin
               r.status = ST_FULL;
            end else if (op == OP_PUSH_FRONT) begin
               stored_values.push_front(value);
            end else begin
               stored_values.push_back(value);
            end
         end
         OP_POP_FRONT, OP_POP_REAR: begin
            if (stored_values.size() == 0) begin
               r.status = ST_EMPTY;
            end else if (op == OP_POP_FRONT) begin
               r.item = stored_values.pop_front();
            end else begin
               r.item = stored_values.pop_back();
            end
         end
         OP_LIST: begin
            if (stored_values.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.last = 1'b0;
               for (n = 0; n < stored_values.size() - 1; n++) begin
                  r.item = stored_values[n];
                  pending_rsp_q.push_back(r);
               end
               r.item = stored_values[stored_values.size() - 1];
               r.last = 1'b1;
            end
         end
         default: return;
      endcase
      if (typed) pending_rsp_q.push_back(typed_rsp);
      else pending_rsp_q.push_back(r);
   endfunction

   // Holds the request until the block takes it, then books the expected responses.
   task automatic send_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value,
                               input bit typed, input rsp_fields_type typed_rsp);
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.value <= value;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
      apply_deque_op(op, value, typed, typed_rsp);
   endtask

   task automatic idle_gap();
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      rsp_fields_type           typed_rsp;
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
      int                       push_pct;
      int                       pick;
      int                       row;
      int                       k;
      int                       n;

      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.op    <= OP_PUSH_FRONT;
      req_bus.value <= '0;

      directed_rows = '{
         '{OP_POP_FRONT,  32'sh0000_0000, 1,  1, ST_EMPTY, 0, 1'b1},
         '{OP_POP_REAR,   32'shdead_beef, 1,  1, ST_EMPTY, 0, 1'b1},
         '{OP_LIST,       32'sh0000_0000, 1,  1, ST_EMPTY, 0, 1'b1},
         '{OP_PUSH_FRONT, 32'sh7fff_ffff, 1,  1, ST_OK,    0, 1'b1},
         '{OP_PUSH_REAR,  32'sh8000_0000, 1,  1, ST_OK,    0, 1'b1},
         '{OP_PUSH_FRONT, 32'shffff_ffff, 1,  1, ST_OK,    0, 1'b1},
         '{OP_PUSH_REAR,  32'sh0000_0000, 1,  1, ST_OK,    0, 1'b1},
         '{OP_LIST,       32'sh0000_0000, 1,  0, ST_OK,    0, 1'b1},
         '{OP_POP_FRONT,  32'sh0000_0000, 1,  0, ST_OK,    0, 1'b1},
         '{OP_POP_REAR,   32'sh0000_0000, 1,  0, ST_OK,    0, 1'b1},
         '{OP_UNUSED_LO,  32'shffff_ffff, 1,  0, ST_OK,    0, 1'b1},
         '{OP_UNUSED_MID, 32'sh1234_5678, 1,  0, ST_OK,    0, 1'b1},
         '{OP_UNUSED_HI,  32'sh0000_0000, 1,  0, ST_OK,    0, 1'b1},
         '{OP_POP_FRONT,  32'sh0000_0000, 1,  0, ST_OK,    0, 1'b1},
         '{OP_POP_REAR,   32'sh0000_0000, 1,  0, ST_OK,    0, 1'b1},
         '{OP_POP_REAR,   32'sh0000_0000, 1,  1, ST_EMPTY, 0, 1'b1},
         '{OP_PUSH_FRONT, 32'sh5555_5555, 16, 0, ST_OK,    0, 1'b1},
         '{OP_PUSH_REAR,  32'shaaaa_aaaa, 16, 0, ST_OK,    0, 1'b1},
         '{OP_PUSH_FRONT, 32'sh1234_5678, 1,  1, ST_FULL,  0, 1'b1},
         '{OP_PUSH_REAR,  32'sh8765_4321, 1,  1, ST_FULL,  0, 1'b1},
         '{OP_LIST,       32'sh0000_0000, 1,  0, ST_OK,    0, 1'b1},
         '{OP_POP_FRONT,  32'sh0000_0000, 4,  0, ST_OK,    0, 1'b1},
         '{OP_POP_REAR,   32'sh0000_0000, 4,  0, ST_OK,    0, 1'b1},
         '{OP_LIST,       32'sh0000_0000, 1,  0, ST_OK,    0, 1'b1}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < NUM_DIRECTED; row++) begin
         typed_rsp.status = directed_rows[row].exp_status;
         typed_rsp.item   = directed_rows[row].exp_item;
         typed_rsp.last   = directed_rows[row].exp_last;
         for (k = 0; k < directed_rows[row].reps; k++) begin
            idle_gap();
            send_request(directed_rows[row].op, directed_rows[row].value + k,
                         directed_rows[row].typed, typed_rsp);
         end
      end

      // Random part: stretches biased toward filling, then draining, then mixed traffic.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         calm_tail = (n >= CALM_TAIL_START);
         case ((n / 22) % 3)
            0: push_pct = 70;
            1: push_pct = 20;
            default: push_pct = 45;
         endcase
         pick  = $urandom_range(0, 99);
         value = $urandom;
         if (pick < 3) begin
            op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         end else if (pick < 11) begin
            op = OP_LIST;
         end else if (pick < 11 + push_pct) begin
            op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
         end else begin
            op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
         end
         idle_gap();
         send_request(op, value, 1'b0, typed_rsp);
      end
      req_bus.valid <= 1'b0;

      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : drive_rsp_ready
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!calm_tail && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // Sampled at the falling edge, where valid and ready are settled for the coming handshake.
   always @(negedge clock) begin : check_rsp
      rsp_fields_type exp_rsp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp_q.size() == 0) begin
            $error("unexpected response transaction: status %0d item %0d last %0d",
                   rsp_bus.status, rsp_bus.item, rsp_bus.last);
            fail_count++;
         end else begin
            exp_rsp = pending_rsp_q.pop_front();
            if (rsp_bus.status !== exp_rsp.status) begin
               $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_bus.status);
               fail_count++;
            end
            if (rsp_bus.item !== exp_rsp.item) begin
               $error("item: expected %0d, actual %0d", exp_rsp.item, rsp_bus.item);
               fail_count++;
            end
            if (rsp_bus.last !== exp_rsp.last) begin
               $error("last: expected %0d, actual %0d", exp_rsp.last, rsp_bus.last);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
